// File: src/bafd_pkg.sv
// Package for the battery frame decoder: word types, frame layout constants,
// sequencer states and the hex character helpers.
// No dependencies.
package bafd_pkg;

  // Default sizes handed to the top level
  localparam int DEF_NUM_CELLS   = 14;
  localparam int DEF_FRAME_BYTES = 166;

  // Frame layout
  localparam logic [7:0] CH_START   = 8'h3A;  // ':'
  localparam logic [7:0] CH_END     = 8'h7E;  // '~'
  localparam logic [7:0] END_POS    = 8'd165;
  localparam int         CELL_BASE  = 31;
  localparam int         NUM_FIELDS = 6;

  // Field character ranges: charge, discharge, status, percent, amp-hours, capacity
  localparam logic [7:0] FIELD_FIRST [NUM_FIELDS] = '{8'd87, 8'd91, 8'd111,
                                                      8'd153, 8'd157, 8'd163};
  localparam logic [7:0] FIELD_LAST  [NUM_FIELDS] = '{8'd90, 8'd94, 8'd114,
                                                      8'd154, 8'd158, 8'd163};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_frame;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  cell_index;
    logic [15:0] cell_voltage;
    logic [15:0] pack_voltage;
    logic [15:0] charge_current;
    logic [15:0] discharge_current;
    logic [15:0] status_word;
    logic [15:0] charge_percent;
    logic [15:0] charge_amp_hours;
    logic [15:0] capacity_code;
    logic        last_item;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  // Digit value of one character: ch-48 for '0'..'9', else ch-55, modulo 2^16
  function automatic logic [15:0] char_digit(input logic [7:0] ch);
    logic [15:0] d;
    if (ch >= 8'd48 && ch <= 8'd57) begin
      d = {8'd0, ch} - 16'd48;
    end else begin
      d = {8'd0, ch} - 16'd55;
    end
    return d;
  endfunction

  // Digit weighted by 16^k, modulo 2^16
  function automatic logic [15:0] char_term(input logic [7:0] ch, input logic [1:0] k);
    logic [15:0] d;
    d = char_digit(ch);
    return d << {k, 2'b00};
  endfunction

endpackage

// File: src/bms_ascii_frame_decoder.sv
// Results follow the frame-end byte (165): a rejected frame goes straight to the emit sweep,
// while an accepted one first copies pending cells to kept memory in the commit sweep.
// Throughput: one byte per cycle while in_stall is low, then one result word per cycle
// while out_stall is low; input stalls from byte 165 until the last result word is taken.
// Reset (rst, synchronous): idle past frame end; kept fields and pack are cleared,
// and kept cells read zero via per-cell valid bits.
module bms_ascii_frame_decoder #(
  parameter int NUM_CELLS   = bafd_pkg::DEF_NUM_CELLS,
  parameter int FRAME_BYTES = bafd_pkg::DEF_FRAME_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bafd_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bafd_pkg::out_word_t out_data
);
  import bafd_pkg::*;

  localparam int CIW      = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int CW       = $clog2(NUM_CELLS + 1);
  localparam int CELL_END = CELL_BASE + 4 * NUM_CELLS;

  // Sequencer state and byte tracking
  state_t      state, state_next;
  logic [7:0]  pos;
  logic        start_ok;
  logic        ok;
  logic [15:0] cell_acc;

  // Cell memories: pending is written per cell, kept has valid bits for reset zero
  logic [15:0]          pend_mem [NUM_CELLS];
  logic [15:0]          kept_mem [NUM_CELLS];
  logic [NUM_CELLS-1:0] kvalid;
  logic [15:0]          pend_rd;
  logic [15:0]          kept_rd;

  logic [15:0] pend_fields [NUM_FIELDS];
  logic [15:0] fld_next    [NUM_FIELDS];
  logic [15:0] kept_fields [NUM_FIELDS];
  logic [15:0] kept_pack;
  logic [15:0] pack_acc;

  // Commit sweep
  logic [CW-1:0]  cnt;
  logic           rd_v;
  logic [CIW-1:0] rd_i;

  // Emit sweep
  logic [CW-1:0] e;
  logic [3:0]    out_idx;

  // Byte decode
  logic           in_acc;
  logic [7:0]     pos_eff;
  logic           active;
  logic           in_cells;
  logic [7:0]     cell_off;
  logic [CIW-1:0] cell_sel;
  logic [1:0]     cell_sub;
  logic [15:0]    cell_sum;
  logic           frame_end;
  logic           end_ok;
  logic           emit_fire;
  logic           commit_done;

  assign in_acc   = in_valid && !in_stall;
  assign pos_eff  = in_data.first_of_frame ? 8'd0 : pos;
  assign active   = pos_eff < 8'(FRAME_BYTES);
  assign in_cells = (pos_eff >= 8'(CELL_BASE)) && (pos_eff < 8'(CELL_END));
  assign cell_off = pos_eff - 8'(CELL_BASE);
  assign cell_sel = cell_off[CIW+1:2];
  assign cell_sub = cell_off[1:0];
  assign cell_sum = (cell_sub == 2'd0 ? 16'd0 : cell_acc)
                    + char_term(in_data.data_byte, 2'd3 - cell_sub);
  assign frame_end   = in_acc && active && (pos_eff == END_POS);
  assign end_ok      = start_ok && (in_data.data_byte == CH_END);
  assign emit_fire   = !out_valid || !out_stall;
  assign commit_done = (cnt == CW'(NUM_CELLS));

  // Field accumulation for the current byte
  always_comb begin
    for (int i = 0; i < NUM_FIELDS; i++) begin
      fld_next[i] = pend_fields[i];
      if (pos_eff >= FIELD_FIRST[i] && pos_eff <= FIELD_LAST[i]) begin
        fld_next[i] = (pos_eff == FIELD_FIRST[i] ? 16'd0 : pend_fields[i])
                      + char_term(in_data.data_byte, 2'(FIELD_LAST[i] - pos_eff));
      end
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      ST_RECV: begin
        in_stall = 1'b0;
        if (frame_end) begin
          state_next = end_ok ? ST_COMMIT : ST_EMIT;
        end
      end
      ST_COMMIT: begin
        if (commit_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire && e == CW'(NUM_CELLS)) begin
          state_next = ST_RECV;
        end
      end
      default: begin
        state_next = ST_RECV;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RECV;
    end else begin
      state <= state_next;
    end
  end

  // Advance position, check delimiters, accumulate fields
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= 8'(FRAME_BYTES);
      start_ok <= 1'b0;
      ok       <= 1'b0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        pend_fields[i] <= 16'd0;
      end
    end else if (in_acc) begin
      if (in_data.first_of_frame) begin
        pos <= 8'd1;
      end else if (active) begin
        pos <= pos + 8'd1;
      end
      if (active) begin
        if (pos_eff == 8'd0) begin
          start_ok <= (in_data.data_byte == CH_START);
        end
        for (int i = 0; i < NUM_FIELDS; i++) begin
          pend_fields[i] <= fld_next[i];
        end
      end
      if (frame_end) begin
        ok <= end_ok;
      end
    end
  end

  // Build one cell value; write it at its fourth character
  always_ff @(posedge clk) begin
    if (in_acc && active && in_cells) begin
      cell_acc <= cell_sum;
      if (cell_sub == 2'd3) begin
        pend_mem[cell_sel] <= cell_sum;
      end
    end
  end

  // Pending memory read port
  always_ff @(posedge clk) begin
    if (state == ST_COMMIT && !commit_done) begin
      pend_rd <= pend_mem[cnt[CIW-1:0]];
    end
  end

  // Commit sweep: read pending, write kept in the following cycle, sum the pack
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rd_v      <= 1'b0;
      kvalid    <= '0;
      kept_pack <= 16'd0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        kept_fields[i] <= 16'd0;
      end
    end else if (state == ST_COMMIT) begin
      rd_v <= !commit_done;
      rd_i <= cnt[CIW-1:0];
      if (!commit_done) begin
        cnt <= cnt + CW'(1);
      end
      if (rd_v) begin
        kvalid[rd_i] <= 1'b1;
        pack_acc     <= pack_acc + pend_rd;
      end
      if (commit_done) begin
        kept_pack <= pack_acc + pend_rd;
        for (int i = 0; i < NUM_FIELDS; i++) begin
          kept_fields[i] <= pend_fields[i];
        end
      end
    end else begin
      cnt      <= '0;
      rd_v     <= 1'b0;
      pack_acc <= 16'd0;
    end
  end

  // Kept memory write port; reads never meet writes since the sweeps do not overlap
  always_ff @(posedge clk) begin
    if (state == ST_COMMIT && rd_v) begin
      kept_mem[rd_i] <= pend_rd;
    end
  end

  // Emit sweep: read kept cell into the output register when the slot frees
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && emit_fire && e != CW'(NUM_CELLS)) begin
      kept_rd <= kvalid[e[CIW-1:0]] ? kept_mem[e[CIW-1:0]] : 16'd0;
      out_idx <= 4'(e);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e         <= '0;
      out_valid <= 1'b0;
    end else if (state == ST_EMIT) begin
      if (emit_fire) begin
        if (e != CW'(NUM_CELLS)) begin
          out_valid <= 1'b1;
          e         <= e + CW'(1);
        end else begin
          out_valid <= 1'b0;
          e         <= '0;
        end
      end
    end else begin
      e <= '0;
    end
  end

  // Output word from the held registers
  always_comb begin
    out_data.accepted          = ok;
    out_data.cell_index        = out_idx;
    out_data.cell_voltage      = kept_rd;
    out_data.pack_voltage      = kept_pack;
    out_data.charge_current    = kept_fields[0];
    out_data.discharge_current = kept_fields[1];
    out_data.status_word       = kept_fields[2];
    out_data.charge_percent    = kept_fields[3];
    out_data.charge_amp_hours  = kept_fields[4];
    out_data.capacity_code     = kept_fields[5];
    out_data.last_item         = (out_idx == 4'(NUM_CELLS - 1));
  end

endmodule

// File: src/bafd_checker.sv
// Port-level checks for the battery frame decoder, bound to its top level.
// Depends on bafd_pkg word types.
module bafd_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input bafd_pkg::out_word_t out_data
);
  import bafd_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  // Take no byte while results are pending
  a_no_input_during_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while results pending");

  // Advance the cell index by one within a run
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last_item |=>
      out_valid && out_data.cell_index == $past(out_data.cell_index) + 4'd1)
    else $error("cell index did not advance");

  // Keep the accepted flag and pack voltage constant over one run
  a_run_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last_item |=>
      out_data.accepted == $past(out_data.accepted) &&
      out_data.pack_voltage == $past(out_data.pack_voltage))
    else $error("frame values changed within a run");

endmodule

bind bms_ascii_frame_decoder bafd_checker u_bafd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/sv/bms_ascii_frame_decoder_tb.sv
// Testbench for bms_ascii_frame_decoder: directed frames from a table, then random
// frames; every cell word is checked against a frame decoder model held here.
// Depends on bafd_pkg and the decoder RTL.
`timescale 1ns / 1ps
module bms_ascii_frame_decoder_tb;
  import bafd_pkg::*;

  localparam int         CELLS          = 14;
  localparam int         FRAME_LEN      = 166;
  localparam int         LAST_POS       = 165;
  localparam int         CELL_FIRST     = 31;
  localparam int         N_FIELDS       = 6;
  localparam logic [7:0] START_CHAR     = 8'h3A;
  localparam logic [7:0] END_CHAR       = 8'h7E;
  localparam logic [7:0] DIGIT_LO       = 8'h30;
  localparam logic [7:0] DIGIT_HI       = 8'h39;
  localparam int         FLD_FIRST [N_FIELDS] = '{87, 91, 111, 153, 157, 163};
  localparam int         FLD_LAST  [N_FIELDS] = '{90, 94, 114, 154, 158, 163};
  localparam int         HOLD_CYCLES    = 300;
  localparam int         IDLE_LIMIT     = 2000;
  localparam int         DRAIN_CYCLES   = 40;
  localparam int         RANDOM_WORDS   = 256;
  localparam int         SHOWN_ERRORS   = 10;

  typedef enum int {
    FLD_CHARGE,
    FLD_DISCHARGE,
    FLD_STATUS,
    FLD_PERCENT,
    FLD_AMP_HOURS,
    FLD_CAPACITY
  } field_e;

  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_FRAME
  } row_kind_e;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_PERIODIC,
    RX_HEAVY
  } rx_mode_e;

  // One line of the directed plan: a single byte, or a frame filled with one char
  typedef struct {
    row_kind_e  kind;
    logic [7:0] fill;
    logic       sof;
    logic [7:0] head;
    logic [7:0] tail;
    int         span;
    bit         typed;
    out_word_t  want;
  } plan_row_t;

  // Cell word readable at a glance: an all-'F' frame with a bad end mark right after
  // reset commits nothing, so it reports zero kept values and accepted low
  localparam out_word_t ZERO_REJ = '{1'b0, 4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                     16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0};

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  // Decoder model state
  int unsigned rx_pos = FRAME_LEN;
  bit          start_seen;
  logic [15:0] rx_cells    [CELLS];
  logic [15:0] rx_fields   [N_FIELDS];
  logic [15:0] kept_cells  [CELLS];
  logic [15:0] kept_fields [N_FIELDS];
  logic [15:0] kept_pack;
  bit          typed_on;
  out_word_t   typed_word;

  out_word_t   cell_reports_due [$];
  int          mismatches;
  int          words_sent;
  int          burst_left = 20;
  int          idle_cycles;
  int          hold_requests;
  int          hold_served;
  int          hold_left;
  int          mode_left;
  int unsigned stall_tick;
  rx_mode_e    rx_mode = RX_FREE;
  string       hex_digits = "0123456789ABCDEF";
  plan_row_t   plan [$];

  bms_ascii_frame_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Digit value weighted by 16^(chars_after mod 4), wrapped to 16 bits
  function automatic logic [15:0] hex_term(logic [7:0] ch, int unsigned chars_after);
    logic [15:0] digit;
    if (ch >= DIGIT_LO && ch <= DIGIT_HI) begin
      digit = {8'd0, ch} - 16'd48;
    end else begin
      digit = {8'd0, ch} - 16'd55;
    end
    return digit << (4 * (chars_after % 4));
  endfunction

  // Fold one char into a field accumulator when pos lies in [first, last]
  function automatic logic [15:0] fold_char(int unsigned pos, int unsigned first,
                                            int unsigned last, logic [15:0] acc,
                                            logic [7:0] ch);
    if (pos < first || pos > last) return acc;
    if (pos == first) return hex_term(ch, last - pos);
    return acc + hex_term(ch, last - pos);
  endfunction

  // Advance the frame decoder by one accepted byte; queue the cell words it causes
  function automatic void decode_frame_byte(in_word_t w);
    int unsigned pos;
    int unsigned c;
    bit          ok;
    logic [15:0] pack;
    out_word_t   r;
    if (w.first_of_frame) rx_pos = 0;
    pos = rx_pos;
    if (pos >= FRAME_LEN) return;
    rx_pos = pos + 1;
    if (pos == 0) begin
      start_seen = (w.data_byte == START_CHAR);
      return;
    end
    if (pos >= CELL_FIRST && pos < CELL_FIRST + 4 * CELLS) begin
      c = (pos - CELL_FIRST) / 4;
      rx_cells[c] = fold_char(pos, CELL_FIRST + 4 * c, CELL_FIRST + 4 * c + 3,
                              rx_cells[c], w.data_byte);
    end
    for (int i = 0; i < N_FIELDS; i++) begin
      rx_fields[i] = fold_char(pos, FLD_FIRST[i], FLD_LAST[i], rx_fields[i], w.data_byte);
    end
    if (pos != LAST_POS) return;
    // Commit only a frame with both delimiters
    ok = start_seen && (w.data_byte == END_CHAR);
    if (ok) begin
      pack = '0;
      for (int i = 0; i < CELLS; i++) begin
        kept_cells[i] = rx_cells[i];
        pack += rx_cells[i];
      end
      kept_fields = rx_fields;
      kept_pack   = pack;
    end
    for (int i = 0; i < CELLS; i++) begin
      r.accepted          = ok;
      r.cell_voltage      = kept_cells[i];
      r.pack_voltage      = kept_pack;
      r.charge_current    = kept_fields[FLD_CHARGE];
      r.discharge_current = kept_fields[FLD_DISCHARGE];
      r.status_word       = kept_fields[FLD_STATUS];
      r.charge_percent    = kept_fields[FLD_PERCENT];
      r.charge_amp_hours  = kept_fields[FLD_AMP_HOURS];
      r.capacity_code     = kept_fields[FLD_CAPACITY];
      if (typed_on) r = typed_word;
      r.cell_index = 4'(i);
      r.last_item  = (i == CELLS - 1);
      cell_reports_due.push_back(r);
    end
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS) $display("%0t ERROR %s", $time, msg);
  endfunction

  // Compare a delivered cell word with the oldest one due, field by field
  function automatic void check_report(out_word_t got);
    out_word_t want;
    string     bad;
    if (cell_reports_due.size() == 0) begin
      note_failure($sformatf("unexpected cell word %h", got));
      return;
    end
    want = cell_reports_due.pop_front();
    bad  = "";
    if (got.accepted !== want.accepted)                   bad = {bad, " accepted"};
    if (got.cell_index !== want.cell_index)               bad = {bad, " cell_index"};
    if (got.cell_voltage !== want.cell_voltage)           bad = {bad, " cell_voltage"};
    if (got.pack_voltage !== want.pack_voltage)           bad = {bad, " pack_voltage"};
    if (got.charge_current !== want.charge_current)       bad = {bad, " charge_current"};
    if (got.discharge_current !== want.discharge_current) bad = {bad, " discharge_current"};
    if (got.status_word !== want.status_word)             bad = {bad, " status_word"};
    if (got.charge_percent !== want.charge_percent)       bad = {bad, " charge_percent"};
    if (got.charge_amp_hours !== want.charge_amp_hours)   bad = {bad, " charge_amp_hours"};
    if (got.capacity_code !== want.capacity_code)         bad = {bad, " capacity_code"};
    if (got.last_item !== want.last_item)                 bad = {bad, " last_item"};
    if (bad != "") begin
      note_failure($sformatf("cell word mismatch in%s: expected %h, got %h", bad, want, got));
    end
  endfunction

  function automatic plan_row_t byte_row(logic [7:0] ch, logic sof);
    plan_row_t row;
    row.kind  = ROW_BYTE;
    row.fill  = ch;
    row.sof   = sof;
    row.head  = ch;
    row.tail  = ch;
    row.span  = 1;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic plan_row_t frame_row(logic [7:0] fill, logic [7:0] head,
                                          logic [7:0] tail, int span, bit typed,
                                          out_word_t want);
    plan_row_t row;
    row.kind  = ROW_FRAME;
    row.fill  = fill;
    row.sof   = 1'b1;
    row.head  = head;
    row.tail  = tail;
    row.span  = span;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  // Offer one word, hold it until taken, then decode it; idle between bursts
  task automatic send_word(in_word_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_frame_byte(w);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
  endtask

  // Check every word that leaves the block
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_report(out_data);
  end

  // Receiver: switch between stall patterns; serve long hold-off requests
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(10, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      stall_tick <= stall_tick + 1;
      case (rx_mode)
        RX_FREE:     out_stall <= 1'b0;
        RX_RANDOM:   out_stall <= ($urandom_range(0, 99) < 40);
        RX_PERIODIC: out_stall <= (stall_tick[1:0] == 2'b11);
        default:     out_stall <= ($urandom_range(0, 99) < 80);
      endcase
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    in_word_t w;
    int       pick;
    int       span;
    int       frames_random;
    int       words_base;

    foreach (rx_cells[i]) begin
      rx_cells[i]   = '0;
      kept_cells[i] = '0;
    end
    foreach (rx_fields[i]) begin
      rx_fields[i]   = '0;
      kept_fields[i] = '0;
    end
    kept_pack = '0;

    // Directed plan: idle bytes, restarts, a rejected extreme frame after reset
    plan.push_back(byte_row(8'h00, 1'b0));
    plan.push_back(byte_row(8'hFF, 1'b0));
    plan.push_back(byte_row(START_CHAR, 1'b1));
    plan.push_back(byte_row("7", 1'b0));
    plan.push_back(byte_row(8'h80, 1'b0));
    plan.push_back(frame_row("F", START_CHAR, "X", FRAME_LEN, 1'b1, ZERO_REJ));
    plan.push_back(byte_row("A", 1'b0));
    plan.push_back(byte_row(START_CHAR, 1'b1));
    plan.push_back(byte_row(END_CHAR, 1'b1));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed plan
    foreach (plan[k]) begin
      if (plan[k].kind == ROW_BYTE) begin
        w.data_byte      = plan[k].fill;
        w.first_of_frame = plan[k].sof;
        send_word(w);
      end else begin
        typed_on   = plan[k].typed;
        typed_word = plan[k].want;
        for (int p = 0; p < plan[k].span; p++) begin
          w.first_of_frame = (p == 0);
          w.data_byte      = (p == 0) ? plan[k].head :
                             (p == LAST_POS) ? plan[k].tail : plan[k].fill;
          send_word(w);
        end
        typed_on = 1'b0;
      end
    end

    // Random frames: first well formed, others may have bad marks or be cut short
    words_base    = words_sent;
    frames_random = 0;
    while (words_sent - words_base < RANDOM_WORDS) begin
      pick = (frames_random == 0) ? 0 : $urandom_range(0, 99);
      span = (pick >= 90) ? $urandom_range(1, LAST_POS) : FRAME_LEN;
      if (span > RANDOM_WORDS - (words_sent - words_base)) begin
        span = RANDOM_WORDS - (words_sent - words_base);
      end
      for (int p = 0; p < span; p++) begin
        if ($urandom_range(0, 99) < 85) begin
          w.data_byte = hex_digits[$urandom_range(0, 15)];
        end else begin
          w.data_byte = 8'($urandom_range(0, 255));
        end
        if (p == 0) begin
          w.data_byte = (pick >= 70 && pick < 80) ? 8'($urandom_range(0, 255)) : START_CHAR;
        end
        if (p == LAST_POS) begin
          w.data_byte = (pick >= 80 && pick < 90) ? 8'($urandom_range(0, 255)) : END_CHAR;
        end
        w.first_of_frame = (p == 0);
        // Hold the receiver off across the first frame end so the input backs up
        if (frames_random == 0 && p == LAST_POS - 15) hold_requests++;
        send_word(w);
      end
      frames_random++;
      // Drop some noise between frames
      if ($urandom_range(0, 99) < 30) begin
        repeat ($urandom_range(1, 4)) begin
          w.data_byte      = 8'($urandom_range(0, 255));
          w.first_of_frame = ($urandom_range(0, 9) == 0);
          send_word(w);
        end
      end
    end

    in_valid <= 1'b0;
    while (cell_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
src/bafd_pkg.sv
src/bms_ascii_frame_decoder.sv
src/bafd_checker.sv
tb/sv/bms_ascii_frame_decoder_tb.sv
